// ----- rtl/core/masked_depth_to_point_assert.svh -----
// Assertion macros for the depth-to-point block.
`ifndef MASKED_DEPTH_TO_POINT_ASSERT_SVH
`define MASKED_DEPTH_TO_POINT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MDP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a delay set by the argument n.
`define MDP_ASSERT_DELAY(name, ante, cons, n, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mdp_pkg.sv -----
// Shared types and constants for the depth-to-point block.
`default_nettype none

package mdp_pkg;

  // APB register map, one 32-bit word per register
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_BOX_LEFT    = 3'd0,
    REG_BOX_TOP     = 3'd1,
    REG_BOX_WIDTH   = 3'd2,
    REG_BOX_HEIGHT  = 3'd3,
    REG_CENTER_X    = 3'd4,
    REG_CENTER_Y    = 3'd5,
    REG_FOCAL_INV_X = 3'd6,
    REG_FOCAL_INV_Y = 3'd7
  } mdp_reg_t;

  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned CENTER_W  = 16;
  localparam int unsigned XY_W      = 24;
  localparam int unsigned FRAC_PIX  = 4;   // centers are in sixteenths of a pixel

  localparam int unsigned XY_POS_LIM = 8388607;
  localparam int unsigned XY_NEG_LIM = 8388608;

  localparam int unsigned CENTER_X_RESET  = 5120;
  localparam int unsigned CENTER_Y_RESET  = 3840;
  localparam int unsigned FOCAL_INV_RESET = 31957;

  // register stages from an accepted word to its result
  localparam int unsigned PIPE_STAGES = 5;

endpackage

`default_nettype wire

// ----- rtl/core/masked_depth_to_point.sv -----
// Top level: box mask, per-axis back-projection pipelines and result strobe.
//
// Usage: one depth pixel (pixel_col, pixel_row, depth_mm, depth_nan) is taken
// at each rising edge where start is high and busy is low. busy stays low, so
// a pixel can be given on every clock.
// Each pixel gives exactly one point on point_x, point_y, point_z, point_nan,
// shown for one cycle with done high once it leaves the pipeline.
// The axis pipeline has five register stages: offset,
// offset times depth, two partial products with the inverse focal length,
// round, clamp. Throughput is one point per clock.
// A pixel outside the box (strict on all sides) gives an all-zero point; a
// NaN pixel inside it gives point_nan with zero coordinates.
// Configuration uses the APB port, one 32-bit register per word address.
// The user must change it only while no pixel is in flight; not enforced.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults. The receiver cannot stall: a point must be taken when done is high.
`default_nettype none

module masked_depth_to_point import mdp_pkg::*; #(
  parameter int COORD_BITS      = 12,
  parameter int FOCAL_FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic [COORD_BITS-1:0] pixel_row,
  input  logic [DEPTH_W-1:0]    depth_mm,
  input  logic                  depth_nan,
  output logic                  done,
  output logic [XY_W-1:0]       point_x,
  output logic [XY_W-1:0]       point_y,
  output logic [DEPTH_W-1:0]    point_z,
  output logic                  point_nan
);

  logic [COORD_BITS-1:0]      box_left;
  logic [COORD_BITS-1:0]      box_top;
  logic [COORD_BITS-1:0]      box_width;
  logic [COORD_BITS-1:0]      box_height;
  logic [CENTER_W-1:0]        center_x;
  logic [CENTER_W-1:0]        center_y;
  logic [FOCAL_FRAC_BITS-1:0] focal_inv_x;
  logic [FOCAL_FRAC_BITS-1:0] focal_inv_y;

  mdp_cfg_regs #(
    .COORD_BITS      (COORD_BITS),
    .FOCAL_FRAC_BITS (FOCAL_FRAC_BITS)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_width   (box_width),
    .box_height  (box_height),
    .center_x    (center_x),
    .center_y    (center_y),
    .focal_inv_x (focal_inv_x),
    .focal_inv_y (focal_inv_y)
  );

  assign busy = 1'b0;

  // box test, right and bottom edges summed one bit wider so they never wrap
  logic [COORD_BITS:0]  box_right;
  logic [COORD_BITS:0]  box_bottom;
  logic                 in_box;
  logic                 keep;
  logic [DEPTH_W-1:0]   depth_eff;
  logic                 accept;

  assign box_right  = {1'b0, box_left} + {1'b0, box_width};
  assign box_bottom = {1'b0, box_top} + {1'b0, box_height};
  assign in_box = (pixel_col > box_left) && ({1'b0, pixel_col} < box_right) &&
                  (pixel_row > box_top) && ({1'b0, pixel_row} < box_bottom);
  assign keep   = in_box && !depth_nan;
  assign accept = start && !busy;
  // zero depth drives both products, and so x and y, to zero
  assign depth_eff = keep ? depth_mm : '0;

  mdp_axis_proj #(
    .COORD_BITS      (COORD_BITS),
    .FOCAL_FRAC_BITS (FOCAL_FRAC_BITS)
  ) u_proj_x (
    .clk    (clk),
    .coord  (pixel_col),
    .center (center_x),
    .depth  (depth_eff),
    .finv   (focal_inv_x),
    .point  (point_x)
  );

  mdp_axis_proj #(
    .COORD_BITS      (COORD_BITS),
    .FOCAL_FRAC_BITS (FOCAL_FRAC_BITS)
  ) u_proj_y (
    .clk    (clk),
    .coord  (pixel_row),
    .center (center_y),
    .depth  (depth_eff),
    .finv   (focal_inv_y),
    .point  (point_y)
  );

  // valid, NaN and z ride alongside the axis pipelines
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] nan_pipe;
  logic [DEPTH_W-1:0]     z_pipe [PIPE_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    nan_pipe  <= {nan_pipe[PIPE_STAGES-2:0], in_box && depth_nan};
    z_pipe[0] <= depth_eff;
    for (int i = 1; i < PIPE_STAGES; i++) begin
      z_pipe[i] <= z_pipe[i-1];
    end
  end

  assign done      = vld[PIPE_STAGES-1];
  assign point_nan = nan_pipe[PIPE_STAGES-1];
  assign point_z   = z_pipe[PIPE_STAGES-1];

`include "masked_depth_to_point_assert.svh"

  `MDP_ASSERT_DELAY(a_word_latency, start && !busy, done, PIPE_STAGES, "result strobe missing after accepted word")
  `MDP_ASSERT_NOW(a_nan_zero, done && point_nan, point_x == '0 && point_y == '0 && point_z == '0, "NaN point carries nonzero coordinates")
  `MDP_ASSERT_NOW(a_masked_zero, done && !point_nan && point_z == '0, point_x == '0 && point_y == '0, "zero-depth point carries nonzero x or y")

endmodule

`default_nettype wire

// ----- rtl/core/mdp_cfg_regs.sv -----
// APB configuration registers for box, principal point and inverse focal lengths.
`default_nettype none

module mdp_cfg_regs import mdp_pkg::*; #(
  parameter int COORD_BITS      = 12,
  parameter int FOCAL_FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  output logic [COORD_BITS-1:0]      box_left,
  output logic [COORD_BITS-1:0]      box_top,
  output logic [COORD_BITS-1:0]      box_width,
  output logic [COORD_BITS-1:0]      box_height,
  output logic [CENTER_W-1:0]        center_x,
  output logic [CENTER_W-1:0]        center_y,
  output logic [FOCAL_FRAC_BITS-1:0] focal_inv_x,
  output logic [FOCAL_FRAC_BITS-1:0] focal_inv_y
);

  logic     wr_en;
  mdp_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = mdp_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left    <= '0;
      box_top     <= '0;
      box_width   <= '0;
      box_height  <= '0;
      center_x    <= CENTER_W'(CENTER_X_RESET);
      center_y    <= CENTER_W'(CENTER_Y_RESET);
      focal_inv_x <= FOCAL_FRAC_BITS'(FOCAL_INV_RESET);
      focal_inv_y <= FOCAL_FRAC_BITS'(FOCAL_INV_RESET);
    end else if (wr_en) begin
      case (reg_sel)
        REG_BOX_LEFT:    box_left    <= pwdata[COORD_BITS-1:0];
        REG_BOX_TOP:     box_top     <= pwdata[COORD_BITS-1:0];
        REG_BOX_WIDTH:   box_width   <= pwdata[COORD_BITS-1:0];
        REG_BOX_HEIGHT:  box_height  <= pwdata[COORD_BITS-1:0];
        REG_CENTER_X:    center_x    <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:    center_y    <= pwdata[CENTER_W-1:0];
        REG_FOCAL_INV_X: focal_inv_x <= pwdata[FOCAL_FRAC_BITS-1:0];
        REG_FOCAL_INV_Y: focal_inv_y <= pwdata[FOCAL_FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BOX_LEFT:    prdata = DATA_W'(box_left);
      REG_BOX_TOP:     prdata = DATA_W'(box_top);
      REG_BOX_WIDTH:   prdata = DATA_W'(box_width);
      REG_BOX_HEIGHT:  prdata = DATA_W'(box_height);
      REG_CENTER_X:    prdata = DATA_W'(center_x);
      REG_CENTER_Y:    prdata = DATA_W'(center_y);
      REG_FOCAL_INV_X: prdata = DATA_W'(focal_inv_x);
      REG_FOCAL_INV_Y: prdata = DATA_W'(focal_inv_y);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/mdp_axis_proj.sv -----
// Five-stage back-projection of one image axis: offset, two multiplies, round, saturate.
`default_nettype none

module mdp_axis_proj import mdp_pkg::*; #(
  parameter int COORD_BITS      = 12,
  parameter int FOCAL_FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic [COORD_BITS-1:0]      coord,
  input  logic [CENTER_W-1:0]        center,
  input  logic [DEPTH_W-1:0]         depth,
  input  logic [FOCAL_FRAC_BITS-1:0] finv,
  output logic [XY_W-1:0]            point
);

  localparam int POS_W     = COORD_BITS + FRAC_PIX;
  localparam int MAG_W     = (POS_W > CENTER_W) ? POS_W : CENTER_W;
  localparam int P1_W      = MAG_W + DEPTH_W;
  localparam int FL        = FOCAL_FRAC_BITS / 2;
  localparam int FH        = FOCAL_FRAC_BITS - FL;
  localparam int PLO_W     = P1_W + FL;
  localparam int PHI_W     = P1_W + FH;
  localparam int SUM_W     = P1_W + FOCAL_FRAC_BITS + 1;
  localparam int OUT_SHIFT = FRAC_PIX + FOCAL_FRAC_BITS;
  localparam int QW        = SUM_W - OUT_SHIFT;

  // stage A: signed offset from the principal point
  logic [MAG_W-1:0]   pos_e;
  logic [MAG_W-1:0]   ctr_e;
  logic               neg_in;
  logic [MAG_W-1:0]   mag;
  logic               neg_a;
  logic [DEPTH_W-1:0] depth_a;

  assign pos_e  = MAG_W'({coord, {FRAC_PIX{1'b0}}});
  assign ctr_e  = MAG_W'(center);
  assign neg_in = ctr_e > pos_e;

  always_ff @(posedge clk) begin
    mag     <= neg_in ? (ctr_e - pos_e) : (pos_e - ctr_e);
    neg_a   <= neg_in;
    depth_a <= depth;
  end

  // stage B: offset times depth
  logic [P1_W-1:0] p1;
  logic            neg_b;

  always_ff @(posedge clk) begin
    p1    <= P1_W'(mag) * P1_W'(depth_a);
    neg_b <= neg_a;
  end

  // stage C: split the inverse focal length into two partial products
  logic [PLO_W-1:0] plo;
  logic [PHI_W-1:0] phi;
  logic             neg_c;

  always_ff @(posedge clk) begin
    plo   <= PLO_W'(p1) * PLO_W'(finv[FL-1:0]);
    phi   <= PHI_W'(p1) * PHI_W'(finv[FOCAL_FRAC_BITS-1:FL]);
    neg_c <= neg_b;
  end

  // stage D: combine, round half away from zero on the magnitude, drop fraction
  logic [SUM_W-1:0] full;
  logic [QW-1:0]    q;
  logic             neg_d;

  assign full = (SUM_W'(phi) << FL) + SUM_W'(plo) + (SUM_W'(1) << (OUT_SHIFT - 1));

  always_ff @(posedge clk) begin
    q     <= full[SUM_W-1:OUT_SHIFT];
    neg_d <= neg_c;
  end

  // stage E: clamp and apply the sign
  logic [QW-1:0] lim;
  logic [QW-1:0] qs;

  assign lim = neg_d ? QW'(XY_NEG_LIM) : QW'(XY_POS_LIM);
  assign qs  = (q > lim) ? lim : q;

  always_ff @(posedge clk) begin
    point <= neg_d ? XY_W'(~qs + QW'(1)) : XY_W'(qs);
  end

endmodule

`default_nettype wire
